/* hdl/pswbc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pswbc_pkg: shared types and constants of the windowed byte counter
// Field widths, opcodes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package pswbc_pkg;

  localparam int unsigned WINDOW_DEF = 5;

  localparam int unsigned SEC_W   = 32;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned BYTES_W = 48;
  localparam int unsigned SUM_W   = 64;

  localparam logic [BYTES_W-1:0] BUCKET_MAX = {BYTES_W{1'b1}};

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_LAST,
    S_HOLD
  } state_t;

  typedef struct packed {
    logic record;  // add the packet to its direction
    logic start;   // capture query time, restart the walk
    logic issue;   // read one bucket of each ring and step back
    logic load;    // capture the result into the output register
  } cmd_t;

  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } status_t;

endpackage
`default_nettype wire

/* hdl/pswbc_item_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pswbc_item_if: input item channel
// Valid/ready channel carrying one packet record or query item.
// ----------------------------------------------------------------------------
interface pswbc_item_if;
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic [pswbc_pkg::SEC_W-1:0]  time_sec;
  logic [pswbc_pkg::LEN_W-1:0]  packet_length;
  logic                         outgoing;

  modport source (output valid, opcode, time_sec, packet_length, outgoing, input ready);
  modport sink   (input valid, opcode, time_sec, packet_length, outgoing, output ready);
endinterface
`default_nettype wire

/* hdl/pswbc_result_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pswbc_result_if: query result channel
// Valid/ready channel carrying window sums, totals and the last packet second.
// ----------------------------------------------------------------------------
interface pswbc_result_if;
  logic                         valid;
  logic                         ready;
  logic [pswbc_pkg::SUM_W-1:0]  sent_window_bytes;
  logic [pswbc_pkg::SUM_W-1:0]  recv_window_bytes;
  logic [pswbc_pkg::SUM_W-1:0]  total_sent_bytes;
  logic [pswbc_pkg::SUM_W-1:0]  total_recv_bytes;
  logic [pswbc_pkg::SEC_W-1:0]  last_packet_second;

  modport source (output valid, sent_window_bytes, recv_window_bytes, total_sent_bytes,
                  total_recv_bytes, last_packet_second, input ready);
  modport sink   (input valid, sent_window_bytes, recv_window_bytes, total_sent_bytes,
                  total_recv_bytes, last_packet_second, output ready);
endinterface
`default_nettype wire

/* hdl/per_second_windowed_byte_counter_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// per_second_windowed_byte_counter_core: per-connection traffic meter
// Keeps wrapping byte totals and a ring of one-second buckets per direction.
// ----------------------------------------------------------------------------
// Usage:
//   items   - valid/ready channel. opcode 0 records a packet (time_sec,
//             packet_length, outgoing); opcode 1 queries at time_sec.
//   results - valid/ready channel, one transfer per query: window sums of
//             both directions, both running totals and the last packet second.
// Sequencing:
//   A packet record is taken in idle; items is ready again the next cycle.
//   A query walks both rings together, one bucket per cycle through the
//   registered bucket memory read port, then passes the last and hold
//   states; the result is loaded into the output register on leaving hold.
// Stalls:
//   The output register holds a finished result while the receiver stalls;
//   records are still taken meanwhile. A further query walks, then waits
//   until the output register frees before items is ready again.
// Reset (rst, synchronous): clears totals, last second, all bucket valid
//   bits and ring heads; no clearing pass over the bucket memory is needed.
// ----------------------------------------------------------------------------
module per_second_windowed_byte_counter_core #(
  parameter int unsigned WINDOW_SECONDS = pswbc_pkg::WINDOW_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  pswbc_item_if.sink      items,
  pswbc_result_if.source  results
);
  pswbc_pkg::cmd_t    cmd;
  pswbc_pkg::status_t sts;

  // sequencer: decides when to take an item and drives the walk
  pswbc_ctrl #(.WINDOW_SECONDS(WINDOW_SECONDS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .opcode   (items.opcode),
    .sts      (sts),
    .in_ready (items.ready),
    .cmd      (cmd)
  );

  // rings, totals and the output register
  pswbc_dp #(.WINDOW_SECONDS(WINDOW_SECONDS)) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .time_sec           (items.time_sec),
    .packet_length      (items.packet_length),
    .outgoing           (items.outgoing),
    .out_ready          (results.ready),
    .sts                (sts),
    .out_valid          (results.valid),
    .sent_window_bytes  (results.sent_window_bytes),
    .recv_window_bytes  (results.recv_window_bytes),
    .total_sent_bytes   (results.total_sent_bytes),
    .total_recv_bytes   (results.total_recv_bytes),
    .last_packet_second (results.last_packet_second)
  );

  // a loaded result shows up on the result channel the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> results.valid)
    else $error("loaded result not presented");

  // a query transfer blocks further items while the walk runs
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready && items.opcode == pswbc_pkg::OP_QUERY) |=> !items.ready)
    else $error("item taken during a bucket walk");

  // never load over a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!results.valid || results.ready))
    else $error("result overwritten before transfer");

endmodule
`default_nettype wire

/* hdl/pswbc_ring.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pswbc_ring: one direction's ring of one-second buckets
// Bucket memory with a cached head entry; walks newest to oldest on a query.
// ----------------------------------------------------------------------------
module pswbc_ring #(
  parameter int unsigned WINDOW_SECONDS = pswbc_pkg::WINDOW_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           record,
  input  wire logic                           start,
  input  wire logic                           issue,
  input  wire logic [pswbc_pkg::SEC_W-1:0]    sec,
  input  wire logic [pswbc_pkg::LEN_W-1:0]    len,
  input  wire logic [pswbc_pkg::SEC_W-1:0]    qtime,
  output logic      [pswbc_pkg::SUM_W-1:0]    sum
);
  localparam int unsigned IW = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_SECONDS - 1);
  localparam logic [pswbc_pkg::SEC_W:0] SPAN = (pswbc_pkg::SEC_W + 1)'(WINDOW_SECONDS);

  logic [pswbc_pkg::BYTES_W-1:0] mem_bytes [WINDOW_SECONDS];
  logic [pswbc_pkg::SEC_W-1:0]   mem_sec   [WINDOW_SECONDS];
  logic [WINDOW_SECONDS-1:0]     valid;

  logic [IW-1:0]                 head;
  logic [pswbc_pkg::BYTES_W-1:0] head_bytes;
  logic [pswbc_pkg::SEC_W-1:0]   head_sec;
  logic [IW-1:0]                 widx;
  logic                          cut;
  logic                          s1_live;
  logic [IW-1:0]                 s1_idx;
  logic                          s1_valid;
  logic [pswbc_pkg::BYTES_W-1:0] rd_bytes;
  logic [pswbc_pkg::SEC_W-1:0]   rd_sec;

  logic                          hit;
  logic [IW-1:0]                 head_inc;
  logic [IW-1:0]                 widx_dec;
  logic [pswbc_pkg::BYTES_W:0]   bump;
  logic [IW-1:0]                 wr_addr;
  logic [pswbc_pkg::BYTES_W-1:0] wr_bytes;
  logic                          stale;
  logic                          drop;

  always_comb begin
    hit      = valid[head] && (head_sec == sec);
    head_inc = (head == LAST_IDX) ? '0 : head + IW'(1);
    widx_dec = (widx == '0) ? LAST_IDX : widx - IW'(1);
    bump     = {1'b0, head_bytes} + (pswbc_pkg::BYTES_W + 1)'(len);
    wr_addr  = hit ? head : head_inc;
    if (hit) begin
      wr_bytes = bump[pswbc_pkg::BYTES_W] ? pswbc_pkg::BUCKET_MAX
                                          : bump[pswbc_pkg::BYTES_W-1:0];
    end else begin
      wr_bytes = pswbc_pkg::BYTES_W'(len);
    end
    // expiry test in one extra bit so an early query never wraps
    stale = ({1'b0, rd_sec} + SPAN) <= {1'b0, qtime};
    drop  = s1_valid && (cut || stale);
  end

  // control: head pointer, valid bits, walk pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      valid   <= '0;
      s1_live <= 1'b0;
    end else begin
      s1_live <= issue;
      if (record && !hit) begin
        head            <= head_inc;
        valid[head_inc] <= 1'b1;
      end
      if (s1_live && drop) begin
        valid[s1_idx] <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (record) begin
      head_bytes <= wr_bytes;
      head_sec   <= sec;
    end
    if (start) begin
      widx <= head;
      cut  <= 1'b0;
      sum  <= '0;
    end else begin
      if (issue) begin
        widx <= widx_dec;
      end
      if (s1_live) begin
        if (!s1_valid || drop) begin
          cut <= 1'b1;
        end else begin
          sum <= sum + pswbc_pkg::SUM_W'(rd_bytes);
        end
      end
    end
    s1_idx   <= widx;
    s1_valid <= valid[widx];
  end

  // bucket memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (record) begin
      mem_bytes[wr_addr] <= wr_bytes;
      mem_sec[wr_addr]   <= sec;
    end
    rd_bytes <= mem_bytes[widx];
    rd_sec   <= mem_sec[widx];
  end

  a_record_valid: assert property (@(posedge clk) disable iff (rst)
    record |=> valid[head])
    else $error("head bucket not valid after a record");

  a_no_record_in_walk: assert property (@(posedge clk) disable iff (rst)
    s1_live |-> !record)
    else $error("record overlaps a bucket walk");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> !s1_live && !issue)
    else $error("query start while a walk is in flight");

endmodule
`default_nettype wire

/* hdl/pswbc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pswbc_ctrl: sequencer of the windowed byte counter
// Takes items in idle, steps the bucket walk, hands the result to the output.
// ----------------------------------------------------------------------------
module pswbc_ctrl #(
  parameter int unsigned WINDOW_SECONDS = pswbc_pkg::WINDOW_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               opcode,
  input  wire pswbc_pkg::status_t sts,
  output logic                    in_ready,
  output pswbc_pkg::cmd_t         cmd
);
  localparam int unsigned IW = (WINDOW_SECONDS > 1) ? $clog2(WINDOW_SECONDS) : 1;
  localparam logic [IW-1:0] LAST_STEP = IW'(WINDOW_SECONDS - 1);

  pswbc_pkg::state_t state, state_next;
  logic [IW-1:0]     cnt;
  logic              take;

  assign take = (state == pswbc_pkg::S_IDLE) && in_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      pswbc_pkg::S_IDLE: begin
        if (take && opcode == pswbc_pkg::OP_QUERY) state_next = pswbc_pkg::S_WALK;
      end
      pswbc_pkg::S_WALK: begin
        if (cnt == LAST_STEP) state_next = pswbc_pkg::S_LAST;
      end
      pswbc_pkg::S_LAST: state_next = pswbc_pkg::S_HOLD;
      pswbc_pkg::S_HOLD: begin
        if (sts.out_free) state_next = pswbc_pkg::S_IDLE;
      end
      default: state_next = pswbc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      pswbc_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.record = take && (opcode == pswbc_pkg::OP_RECORD);
        cmd.start  = take && (opcode == pswbc_pkg::OP_QUERY);
      end
      pswbc_pkg::S_WALK: cmd.issue = 1'b1;
      pswbc_pkg::S_LAST: cmd       = '0;
      pswbc_pkg::S_HOLD: cmd.load  = sts.out_free;
      default:           cmd       = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pswbc_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == pswbc_pkg::S_WALK) begin
        cnt <= cnt + IW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/pswbc_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pswbc_dp: datapath of the windowed byte counter
// Both bucket rings, running totals, last packet second and output register.
// ----------------------------------------------------------------------------
module pswbc_dp #(
  parameter int unsigned WINDOW_SECONDS = pswbc_pkg::WINDOW_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire pswbc_pkg::cmd_t                cmd,
  input  wire logic [pswbc_pkg::SEC_W-1:0]    time_sec,
  input  wire logic [pswbc_pkg::LEN_W-1:0]    packet_length,
  input  wire logic                           outgoing,
  input  wire logic                           out_ready,
  output pswbc_pkg::status_t                  sts,
  output logic                                out_valid,
  output logic      [pswbc_pkg::SUM_W-1:0]    sent_window_bytes,
  output logic      [pswbc_pkg::SUM_W-1:0]    recv_window_bytes,
  output logic      [pswbc_pkg::SUM_W-1:0]    total_sent_bytes,
  output logic      [pswbc_pkg::SUM_W-1:0]    total_recv_bytes,
  output logic      [pswbc_pkg::SEC_W-1:0]    last_packet_second
);
  logic [pswbc_pkg::SUM_W-1:0] sent_total;
  logic [pswbc_pkg::SUM_W-1:0] recv_total;
  logic [pswbc_pkg::SEC_W-1:0] last_second;
  logic [pswbc_pkg::SEC_W-1:0] qtime;
  logic [pswbc_pkg::SUM_W-1:0] sent_sum;
  logic [pswbc_pkg::SUM_W-1:0] recv_sum;

  assign sts.out_free = !out_valid || out_ready;

  pswbc_ring #(.WINDOW_SECONDS(WINDOW_SECONDS)) u_sent (
    .clk    (clk),
    .rst    (rst),
    .record (cmd.record && outgoing),
    .start  (cmd.start),
    .issue  (cmd.issue),
    .sec    (time_sec),
    .len    (packet_length),
    .qtime  (qtime),
    .sum    (sent_sum)
  );

  pswbc_ring #(.WINDOW_SECONDS(WINDOW_SECONDS)) u_recv (
    .clk    (clk),
    .rst    (rst),
    .record (cmd.record && !outgoing),
    .start  (cmd.start),
    .issue  (cmd.issue),
    .sec    (time_sec),
    .len    (packet_length),
    .qtime  (qtime),
    .sum    (recv_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sent_total  <= '0;
      recv_total  <= '0;
      last_second <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.record) begin
        last_second <= time_sec;
        if (outgoing) begin
          sent_total <= sent_total + pswbc_pkg::SUM_W'(packet_length);
        end else begin
          recv_total <= recv_total + pswbc_pkg::SUM_W'(packet_length);
        end
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      qtime <= time_sec;
    end
    if (cmd.load) begin
      sent_window_bytes  <= sent_sum;
      recv_window_bytes  <= recv_sum;
      total_sent_bytes   <= sent_total;
      total_recv_bytes   <= recv_total;
      last_packet_second <= last_second;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/per_second_windowed_byte_counter_core_tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// per_second_windowed_byte_counter_core_tb: self-checking bench of the meter
// Drives packet records and queries over the item channel, predicts query
// results from an in-bench model of the bucket rings and totals or takes a
// hand-written report for typed rows, and compares each result transfer
// field by field. A directed table comes first; random traffic with idle
// bursts, a long receiver hold-off and a drain pause follows.
// ----------------------------------------------------------------------------
module per_second_windowed_byte_counter_core_tb;

  localparam int unsigned SEC_W      = pswbc_pkg::SEC_W;
  localparam int unsigned LEN_W      = pswbc_pkg::LEN_W;
  localparam int unsigned BYTES_W    = pswbc_pkg::BYTES_W;
  localparam int unsigned SUM_W      = pswbc_pkg::SUM_W;
  localparam int unsigned WIN        = pswbc_pkg::WINDOW_DEF;
  localparam int unsigned RAND_ITEMS = 630;
  localparam int unsigned QUIET_TAIL = 100;
  localparam int unsigned HOLD_LEN   = 80;
  localparam int unsigned WDOG_LIMIT = 4000;

  localparam logic DIR_SENT = 1'b1;
  localparam logic DIR_RECV = 1'b0;

  typedef struct packed {
    logic [SUM_W-1:0] sent_win;
    logic [SUM_W-1:0] recv_win;
    logic [SUM_W-1:0] tot_sent;
    logic [SUM_W-1:0] tot_recv;
    logic [SEC_W-1:0] last_sec;
  } report_t;

  // One stimulus item; typed rows carry a hand-written report.
  typedef struct packed {
    logic             op;
    logic [SEC_W-1:0] t;
    logic [LEN_W-1:0] len;
    logic             outg;
    logic             typed;
    report_t          want;
  } item_t;

  logic clk;
  logic rst;

  pswbc_item_if   items_ch ();
  pswbc_result_if results_ch ();

  per_second_windowed_byte_counter_core #(
    .WINDOW_SECONDS(WIN)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  // --------------------------------------------------------------------------
  // Meter model: one bucket ring per direction, index 1 = sent, 0 = received
  // --------------------------------------------------------------------------
  logic [BYTES_W-1:0] bkt_bytes [2][WIN];
  logic [SEC_W-1:0]   bkt_sec   [2][WIN];
  bit                 bkt_valid [2][WIN];
  int unsigned        bkt_head  [2];
  logic [SUM_W-1:0]   dir_total [2];
  logic [SEC_W-1:0]   last_pkt_sec;

  report_t     pending_reports [$];
  item_t       plan [$];
  int unsigned errors;
  int unsigned idle_cycles;
  logic [SEC_W-1:0] clock_sec;

  // Handshake between the sender and the receiver processes.
  bit hold_off_req;
  bit quiet;

  // Walk one ring from the newest bucket back; sum live buckets and drop the
  // first expired one together with everything older.
  function automatic logic [SUM_W-1:0] window_sum(input int d, input logic [SEC_W-1:0] t);
    logic [SUM_W-1:0] sum;
    int unsigned idx;
    bit cut;
    sum = '0;
    idx = bkt_head[d];
    cut = 1'b0;
    for (int k = 0; k < WIN; k++) begin
      if (bkt_valid[d][idx]) begin
        // compare in 64 bits so that an early query time never wraps
        if (cut || ({32'd0, bkt_sec[d][idx]} + 64'(WIN)) <= {32'd0, t}) begin
          cut = 1'b1;
          bkt_valid[d][idx] = 1'b0;
        end else begin
          sum += {16'd0, bkt_bytes[d][idx]};
        end
      end else begin
        // an empty slot ends the chain
        cut = 1'b1;
      end
      idx = (idx + WIN - 1) % WIN;
    end
    return sum;
  endfunction

  // Advance the model by one accepted item; returns 1 when a report is due.
  function automatic bit meter_step(input item_t it, output report_t rep);
    int d;
    int unsigned h;
    logic [BYTES_W:0] acc;
    rep = '0;
    if (it.op == pswbc_pkg::OP_RECORD) begin
      d = (it.outg == DIR_SENT) ? 1 : 0;
      last_pkt_sec = it.t;
      dir_total[d] += {48'd0, it.len};
      h = bkt_head[d];
      if (bkt_valid[d][h] && bkt_sec[d][h] == it.t) begin
        // same second: accumulate, saturating at the bucket width
        acc = {1'b0, bkt_bytes[d][h]} + {33'd0, it.len};
        bkt_bytes[d][h] = acc[BYTES_W] ? pswbc_pkg::BUCKET_MAX : acc[BYTES_W-1:0];
      end else begin
        // new second, or head emptied by expiry: open the next slot
        h = (h + 1) % WIN;
        bkt_head[d] = h;
        bkt_bytes[d][h] = {32'd0, it.len};
        bkt_sec[d][h] = it.t;
        bkt_valid[d][h] = 1'b1;
      end
      return 1'b0;
    end
    rep.sent_win = window_sum(1, it.t);
    rep.recv_win = window_sum(0, it.t);
    rep.tot_sent = dir_total[1];
    rep.tot_recv = dir_total[0];
    rep.last_sec = last_pkt_sec;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, watchdog, result checking
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count cycles without any transfer; a stuck block ends the run here.
  always @(posedge clk) begin
    if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d reports still pending", $time,
               pending_reports.size());
      $display("per_second_windowed_byte_counter_core_tb: errors");
      $finish;
    end
  end

  task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                             input logic [SUM_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // Compare every result transfer against the oldest pending report.
  always @(posedge clk) begin
    report_t exp_rep;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h/%0h", $time,
                 results_ch.sent_window_bytes, results_ch.recv_window_bytes);
      end else begin
        exp_rep = pending_reports.pop_front();
        check_field("sent_window_bytes", exp_rep.sent_win, results_ch.sent_window_bytes);
        check_field("recv_window_bytes", exp_rep.recv_win, results_ch.recv_window_bytes);
        check_field("total_sent_bytes", exp_rep.tot_sent, results_ch.total_sent_bytes);
        check_field("total_recv_bytes", exp_rep.tot_recv, results_ch.total_recv_bytes);
        check_field("last_packet_second", {32'd0, exp_rep.last_sec},
                    {32'd0, results_ch.last_packet_second});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off on request, none at the
  // end. A single countdown keeps one assignment of ready per edge.
  // --------------------------------------------------------------------------
  initial begin
    int unsigned gap;
    gap = 0;
    results_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        results_ch.ready <= 1'b0;
      end else begin
        if (hold_off_req) begin
          hold_off_req = 1'b0;
          gap = HOLD_LEN;
        end else if (gap == 0 && !quiet && $urandom_range(0, 6) == 0) begin
          gap = $urandom_range(1, 6);
        end
        if (gap > 0) begin
          results_ch.ready <= 1'b0;
          gap--;
        end else begin
          results_ch.ready <= 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  task automatic add_row(input logic op, input logic [SEC_W-1:0] t,
                         input logic [LEN_W-1:0] len, input logic outg,
                         input logic typed, input logic [SUM_W-1:0] sw,
                         input logic [SUM_W-1:0] rw, input logic [SUM_W-1:0] ts,
                         input logic [SUM_W-1:0] tr, input logic [SEC_W-1:0] ls);
    item_t row;
    row.op = op;
    row.t = t;
    row.len = len;
    row.outg = outg;
    row.typed = typed;
    row.want = '{sent_win: sw, recv_win: rw, tot_sent: ts, tot_recv: tr, last_sec: ls};
    plan.push_back(row);
  endtask

  // Present one item from a falling edge, hold until the transfer, then move
  // to the next falling edge. Valid stays high; the caller lowers it on a gap.
  task automatic send_item(input item_t it);
    report_t rep;
    items_ch.valid         <= 1'b1;
    items_ch.opcode        <= it.op;
    items_ch.time_sec      <= it.t;
    items_ch.packet_length <= it.len;
    items_ch.outgoing      <= it.outg;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    if (meter_step(it, rep)) begin
      pending_reports.push_back(it.typed ? it.want : rep);
    end
    @(negedge clk);
  endtask

  // Random item: mostly nondecreasing packet seconds, some queries a little
  // ahead of the traffic, a few stray out-of-order packets and far queries.
  function automatic item_t make_item(input bit force_query);
    item_t it;
    int unsigned pick;
    int unsigned len_pick;
    it = '0;
    pick = $urandom_range(0, 99);
    len_pick = $urandom_range(0, 9);
    it.len = (len_pick == 0) ? '0 : (len_pick == 1) ? '1 : LEN_W'($urandom);
    it.outg = 1'($urandom_range(0, 1));
    if (force_query || pick < 12) begin
      it.op = pswbc_pkg::OP_QUERY;
      it.t = (pick == 0) ? SEC_W'($urandom) : clock_sec + $urandom_range(0, WIN + 3);
    end else if (pick < 16) begin
      it.op = pswbc_pkg::OP_RECORD;
      it.t = SEC_W'($urandom);
    end else begin
      if ($urandom_range(0, 39) == 0) begin
        clock_sec += $urandom_range(WIN, 4 * WIN);
      end else if ($urandom_range(0, 2) == 0) begin
        clock_sec += $urandom_range(1, 2);
      end
      it.op = pswbc_pkg::OP_RECORD;
      it.t = clock_sec;
    end
    return it;
  endfunction

  initial begin
    item_t it;
    int unsigned burst_left;

    // start from a clean model and quiet inputs
    for (int d = 0; d < 2; d++) begin
      for (int i = 0; i < WIN; i++) begin
        bkt_bytes[d][i] = '0;
        bkt_sec[d][i]   = '0;
        bkt_valid[d][i] = 1'b0;
      end
      bkt_head[d]  = 0;
      dir_total[d] = '0;
    end
    last_pkt_sec = '0;
    errors       = 0;
    idle_cycles  = 0;
    hold_off_req = 1'b0;
    quiet        = 1'b0;
    burst_left   = 0;
    clock_sec    = '0;

    items_ch.valid         = 1'b0;
    items_ch.opcode        = pswbc_pkg::OP_RECORD;
    items_ch.time_sec      = '0;
    items_ch.packet_length = '0;
    items_ch.outgoing      = DIR_RECV;

    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table. Typed reports follow from the rules at a glance; the
    // rest are left to the model.
    // query straight after reset: nothing recorded
    add_row(pswbc_pkg::OP_QUERY,  32'd0, 16'h0000, DIR_RECV, 1'b1, '0, '0, '0, '0, '0);
    add_row(pswbc_pkg::OP_RECORD, 32'd0, 16'hFFFF, DIR_SENT, 1'b0, '0, '0, '0, '0, '0);
    add_row(pswbc_pkg::OP_RECORD, 32'd0, 16'hFFFF, DIR_RECV, 1'b0, '0, '0, '0, '0, '0);
    // same second accumulates into the head bucket
    add_row(pswbc_pkg::OP_RECORD, 32'd0, 16'h0001, DIR_SENT, 1'b0, '0, '0, '0, '0, '0);
    // early query time: second 0 still live at t = 4
    add_row(pswbc_pkg::OP_QUERY,  32'd4, 16'h0000, DIR_RECV, 1'b1,
            64'h10000, 64'hFFFF, 64'h10000, 64'hFFFF, 32'd0);
    // t = 5 expires both buckets; totals stay
    add_row(pswbc_pkg::OP_QUERY,  32'd5, 16'h0000, DIR_RECV, 1'b1,
            64'h0, 64'h0, 64'h10000, 64'hFFFF, 32'd0);
    // empty head after expiry: open the next slot, zero length
    add_row(pswbc_pkg::OP_RECORD, 32'd5, 16'h0000, DIR_SENT, 1'b0, '0, '0, '0, '0, '0);
    add_row(pswbc_pkg::OP_RECORD, 32'd6, 16'd100,  DIR_SENT, 1'b0, '0, '0, '0, '0, '0);
    // out-of-order second opens a bucket of its own
    add_row(pswbc_pkg::OP_RECORD, 32'd3, 16'd7,    DIR_SENT, 1'b0, '0, '0, '0, '0, '0);
    add_row(pswbc_pkg::OP_RECORD, 32'd9, 16'd1,    DIR_SENT, 1'b0, '0, '0, '0, '0, '0);
    // walk stops at second 3 and drops the older live buckets too
    add_row(pswbc_pkg::OP_QUERY,  32'd10, 16'h0000, DIR_RECV, 1'b0, '0, '0, '0, '0, '0);
    // seven seconds in a row wrap the sent ring
    for (int s = 100; s < 107; s++) begin
      add_row(pswbc_pkg::OP_RECORD, SEC_W'(s), (s % 2 == 0) ? 16'h5555 : 16'hAAAA,
              DIR_SENT, 1'b0, '0, '0, '0, '0, '0);
    end
    add_row(pswbc_pkg::OP_QUERY,  32'd104, 16'h0000, DIR_RECV, 1'b0, '0, '0, '0, '0, '0);
    // seconds at the top of the range: second + window must not wrap
    add_row(pswbc_pkg::OP_RECORD, 32'hFFFF_FFFE, 16'hAAAA, DIR_RECV, 1'b0,
            '0, '0, '0, '0, '0);
    add_row(pswbc_pkg::OP_RECORD, 32'hFFFF_FFFF, 16'h5555, DIR_RECV, 1'b0,
            '0, '0, '0, '0, '0);
    // query ignores length and direction
    add_row(pswbc_pkg::OP_QUERY,  32'hFFFF_FFFF, 16'hFFFF, DIR_SENT, 1'b0,
            '0, '0, '0, '0, '0);
    add_row(pswbc_pkg::OP_RECORD, 32'hFFFF_FFFF, 16'hFFFF, DIR_SENT, 1'b0,
            '0, '0, '0, '0, '0);
    add_row(pswbc_pkg::OP_QUERY,  32'hFFFF_FFFF, 16'h0000, DIR_RECV, 1'b0,
            '0, '0, '0, '0, '0);

    foreach (plan[i]) begin
      if ($urandom_range(0, 3) == 0) begin
        items_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      send_item(plan[i]);
    end

    // Random traffic.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      // re-seed the traffic clock now and then, sometimes just below the wrap
      if (n % 150 == 0) begin
        clock_sec = ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 8)
                                                : SEC_W'($urandom);
      end
      // hold the receiver off while queries keep coming: fill and stall
      if (n == 200) begin
        hold_off_req = 1'b1;
        burst_left = 40;
      end
      // let everything drain before going on
      if (n == 380) begin
        items_ch.valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      if (n == RAND_ITEMS - QUIET_TAIL) quiet = 1'b1;

      if (!quiet && burst_left == 0 && $urandom_range(0, 4) == 0) begin
        items_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      it = make_item(burst_left > 0 && (burst_left % 4 == 0));
      if (burst_left > 0) burst_left--;
      send_item(it);
    end
    items_ch.valid <= 1'b0;

    // drain, then give the walk time to show any stray result
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (WIN + 10) @(posedge clk);

    if (errors == 0) begin
      $display("per_second_windowed_byte_counter_core_tb: clean");
    end else begin
      $display("per_second_windowed_byte_counter_core_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
